/* rtl/modular_exponentiation_assert.svh */
// Assertion macros for the modular exponentiation checker.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define MODEXP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("modexp assertion failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define MODEXP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("modexp assertion failed");

`endif

/* rtl/modexp_pkg.sv */
// Package: widths, types and sequencer states of the modular exponentiation block.
`timescale 1ns / 1ps

package modexp_pkg;

    // Operand width of base, exponent, modulus and result.
    localparam int WIDTH = 16;
    // Bit count of the multiplier step counter (holds WIDTH itself).
    localparam int CNT_W = $clog2(WIDTH + 1);

    typedef logic [WIDTH-1:0] word_t;

    localparam word_t WORD_ONE = word_t'(1);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_RED_WAIT,
        ST_CHECK,
        ST_MUL,
        ST_MUL_WAIT,
        ST_SQR,
        ST_SQR_WAIT,
        ST_FINISH
    } state_t;

    // Request to the shared modular multiplier: r = (a * c) mod n, needs c <= n.
    typedef struct packed {
        logic  start;
        word_t a;
        word_t c;
    } mm_req_t;

    // Response of the shared modular multiplier.
    typedef struct packed {
        logic  done;
        word_t product;
    } mm_rsp_t;

endpackage

/* rtl/modexp_mulmod.sv */
// Bit-serial interleaved modular multiplier, one bit of a per cycle.
`timescale 1ns / 1ps

module modexp_mulmod (
    input  logic                aclk,
    input  logic                aresetn,
    input  modexp_pkg::word_t   n,
    input  modexp_pkg::mm_req_t req,
    output modexp_pkg::mm_rsp_t rsp
);

    modexp_pkg::word_t                 a_reg;
    modexp_pkg::word_t                 c_reg;
    modexp_pkg::word_t                 r_reg;
    modexp_pkg::word_t                 r_next;
    logic [modexp_pkg::CNT_W-1:0]      cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;

    logic [modexp_pkg::WIDTH:0]        dbl;
    logic [modexp_pkg::WIDTH:0]        sum;
    logic [modexp_pkg::WIDTH:0]        n_ext;
    modexp_pkg::word_t                 r_dbl;

    // One step: r = 2r mod n, then r = (r + a_msb*c) mod n.
    always_comb begin
        n_ext  = {1'b0, n};
        dbl    = {r_reg, 1'b0};
        r_dbl  = (dbl >= n_ext) ? modexp_pkg::word_t'(dbl - n_ext)
                                : dbl[modexp_pkg::WIDTH-1:0];
        sum    = {1'b0, r_dbl} + (a_reg[modexp_pkg::WIDTH-1] ? {1'b0, c_reg}
                                                             : {(modexp_pkg::WIDTH+1){1'b0}});
        r_next = (sum >= n_ext) ? modexp_pkg::word_t'(sum - n_ext)
                                : sum[modexp_pkg::WIDTH-1:0];
    end

    // Control: step counter, busy and done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= modexp_pkg::CNT_W'(modexp_pkg::WIDTH);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - modexp_pkg::CNT_W'(1);
                if (cnt_reg == modexp_pkg::CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: operand shift and partial remainder.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg <= req.a;
            c_reg <= req.c;
            r_reg <= '0;
        end else if (busy_reg) begin
            a_reg <= {a_reg[modexp_pkg::WIDTH-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = r_reg;

endmodule

/* rtl/modular_exponentiation.sv */
// Top level: right-to-left square-and-multiply sequencer around one modular multiplier.
//
//  channel   dir   handshake          payload
//  s_        in    s_valid/s_ready    s_base_value, s_exponent
//  m_        out   m_valid/m_ready    m_power_result
//  modulus   in    modulus_wr_en      modulus_wr_data
//
// The base is first reduced mod n; then, from the lowest exponent bit up, a set bit multiplies
// the accumulator by the base and every bit squares the base, until the exponent is zero. All
// of these run on the shared multiplier, one remainder step per cycle. s_ready is high only in
// idle, so the block finishes one item before it takes the next beat.
// Reset sets the modulus to 1 and clears m_valid, not the result data; a modulus of 0 acts as 1.
// A new beat is taken while a finished result still waits on m_ready.
`timescale 1ns / 1ps

module modular_exponentiation (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       modulus_wr_en,
    input  logic [modexp_pkg::WIDTH-1:0] modulus_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [modexp_pkg::WIDTH-1:0] s_base_value,
    input  logic [modexp_pkg::WIDTH-1:0] s_exponent,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [modexp_pkg::WIDTH-1:0] m_power_result
);

    modexp_pkg::state_t  state_reg;
    modexp_pkg::state_t  state_next;
    modexp_pkg::word_t   modulus_reg;
    modexp_pkg::word_t   n_eff;
    modexp_pkg::word_t   base_reg;
    modexp_pkg::word_t   exp_reg;
    modexp_pkg::word_t   acc_reg;
    modexp_pkg::word_t   power_result_reg;
    logic                m_valid_reg;
    logic                s_accept;
    logic                out_load;
    modexp_pkg::mm_req_t mm_req;
    modexp_pkg::mm_rsp_t mm_rsp;

    // Modulus of zero behaves as one.
    assign n_eff = (modulus_reg == '0) ? modexp_pkg::WORD_ONE : modulus_reg;

    modexp_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .n       (n_eff),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            modexp_pkg::ST_IDLE: begin
                if (s_valid) state_next = modexp_pkg::ST_REDUCE;
            end
            modexp_pkg::ST_REDUCE:   state_next = modexp_pkg::ST_RED_WAIT;
            modexp_pkg::ST_RED_WAIT: begin
                if (mm_rsp.done) state_next = modexp_pkg::ST_CHECK;
            end
            modexp_pkg::ST_CHECK: begin
                if (exp_reg == '0)  state_next = modexp_pkg::ST_FINISH;
                else if (exp_reg[0]) state_next = modexp_pkg::ST_MUL;
                else                 state_next = modexp_pkg::ST_SQR;
            end
            modexp_pkg::ST_MUL:      state_next = modexp_pkg::ST_MUL_WAIT;
            modexp_pkg::ST_MUL_WAIT: begin
                if (mm_rsp.done) state_next = modexp_pkg::ST_SQR;
            end
            modexp_pkg::ST_SQR:      state_next = modexp_pkg::ST_SQR_WAIT;
            modexp_pkg::ST_SQR_WAIT: begin
                if (mm_rsp.done) state_next = modexp_pkg::ST_CHECK;
            end
            modexp_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) state_next = modexp_pkg::ST_IDLE;
            end
            default:                 state_next = modexp_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake and multiplier requests.
    always_comb begin
        s_ready      = 1'b0;
        out_load     = 1'b0;
        mm_req.start = 1'b0;
        mm_req.a     = base_reg;
        mm_req.c     = base_reg;
        unique case (state_reg)
            modexp_pkg::ST_IDLE:   s_ready = 1'b1;
            // base mod n as base * 1 mod n
            modexp_pkg::ST_REDUCE: begin
                mm_req.start = 1'b1;
                mm_req.c     = modexp_pkg::WORD_ONE;
            end
            modexp_pkg::ST_MUL: begin
                mm_req.start = 1'b1;
                mm_req.a     = acc_reg;
            end
            modexp_pkg::ST_SQR:    mm_req.start = 1'b1;
            modexp_pkg::ST_FINISH: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign s_accept = s_valid && s_ready;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= modexp_pkg::ST_IDLE;
            modulus_reg <= modexp_pkg::WORD_ONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (modulus_wr_en) modulus_reg <= modulus_wr_data;
            if (out_load)     m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // Working operands and result register.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            base_reg <= s_base_value;
            exp_reg  <= s_exponent;
            acc_reg  <= modexp_pkg::WORD_ONE;
        end
        if (mm_rsp.done) begin
            if (state_reg == modexp_pkg::ST_RED_WAIT) base_reg <= mm_rsp.product;
            if (state_reg == modexp_pkg::ST_MUL_WAIT) acc_reg  <= mm_rsp.product;
            if (state_reg == modexp_pkg::ST_SQR_WAIT) begin
                base_reg <= mm_rsp.product;
                exp_reg  <= {1'b0, exp_reg[modexp_pkg::WIDTH-1:1]};
            end
        end
        if (out_load) power_result_reg <= acc_reg;
    end

    assign m_valid        = m_valid_reg;
    assign m_power_result = power_result_reg;

endmodule

/* rtl/modexp_checker.sv */
// Port-level checker for the modular exponentiation block, bound to the top level.
`timescale 1ns / 1ps
`include "modular_exponentiation_assert.svh"

module modexp_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    // Beats accepted on s_ and not yet delivered on m_.
    always_comb begin
        pend_next = pend_reg;
        if (s_valid && s_ready) pend_next = pend_next + 2'd1;
        if (m_valid && m_ready) pend_next = pend_next - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // A waiting result stays offered.
    `MODEXP_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid)
    // After taking a beat the block is busy.
    `MODEXP_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    // No result without an accepted beat behind it.
    `MODEXP_ASSERT_IMPL(a_no_invented, m_valid, pend_reg != 2'd0)
    // At most one item at work plus one waiting result.
    `MODEXP_ASSERT_IMPL(a_pend_bound, 1'b1, pend_reg != 2'd3)

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (.*);
